// File: rtl/core/sspr_pkg.sv
package sspr_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] MIN_LEN  = 8'd2;
    localparam logic [7:0] MAX_LEN_RESET = 8'd255;

    // parser phases
    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_ONE_FF = 3'd1;
    localparam logic [2:0] PH_ID     = 3'd2;
    localparam logic [2:0] PH_LEN    = 3'd3;
    localparam logic [2:0] PH_ERR    = 3'd4;
    localparam logic [2:0] PH_PARAM  = 3'd5;
    localparam logic [2:0] PH_CSUM   = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_PARAM    = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_BAD_CSUM = 2'd2;
    localparam logic [1:0] KIND_BAD_LEN  = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] device_id;
        logic [7:0] status_error;
        logic [7:0] byte_index;
        logic [7:0] data_byte;
    } sspr_evt_t;

endpackage

// File: rtl/core/sspr_front.sv
module sspr_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              evt_push,
    output sspr_pkg::sspr_evt_t evt
);
    import sspr_pkg::*;

    logic [7:0] max_length_reg;
    logic [2:0] phase_reg, phase_next;
    logic [7:0] packet_id_reg, packet_id_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] error_reg, error_next;
    logic       last_param;

    // compared against the count after this parameter
    assign last_param = ({1'b0, count_reg} + 9'd1 + {1'b0, MIN_LEN}) >= {1'b0, length_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        packet_id_next = packet_id_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        error_next     = error_reg;
        evt_push       = 1'b0;
        evt.kind         = KIND_PARAM;
        evt.device_id    = packet_id_reg;
        evt.status_error = 8'd0;
        evt.byte_index   = 8'd0;
        evt.data_byte    = 8'd0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_ONE_FF:
                begin
                    phase_next = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT;
                end
                PH_ID:
                begin
                    packet_id_next = rx_byte;
                    sum_next       = rx_byte;
                    phase_next     = PH_LEN;
                end
                PH_LEN:
                begin
                    length_next = rx_byte;
                    if (rx_byte < MIN_LEN || rx_byte > max_length_reg)
                    begin
                        phase_next = PH_HUNT;
                        evt_push   = 1'b1;
                        evt.kind   = KIND_BAD_LEN;
                    end
                    else
                    begin
                        sum_next   = sum_reg + rx_byte;
                        phase_next = PH_ERR;
                    end
                end
                PH_ERR:
                begin
                    error_next = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    count_next = 8'd0;
                    phase_next = (length_reg == MIN_LEN) ? PH_CSUM : PH_PARAM;
                end
                PH_PARAM:
                begin
                    evt_push         = 1'b1;
                    evt.kind         = KIND_PARAM;
                    evt.status_error = error_reg;
                    evt.byte_index   = count_reg;
                    evt.data_byte    = rx_byte;
                    sum_next         = sum_reg + rx_byte;
                    count_next       = count_reg + 8'd1;
                    if (last_param)
                    begin
                        phase_next = PH_CSUM;
                    end
                end
                PH_CSUM:
                begin
                    evt_push         = 1'b1;
                    evt.kind         = (rx_byte == ~sum_reg) ? KIND_GOOD : KIND_BAD_CSUM;
                    evt.status_error = error_reg;
                    evt.byte_index   = count_reg;
                    phase_next       = PH_HUNT;
                end
                default:
                begin
                    // hunting, and the unused code
                    phase_next = (rx_byte == HDR_BYTE) ? PH_ONE_FF : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LEN_RESET;
            phase_reg      <= PH_HUNT;
            packet_id_reg  <= 8'd0;
            length_reg     <= 8'd0;
            count_reg      <= 8'd0;
            sum_reg        <= 8'd0;
            error_reg      <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_length_reg <= cfg_wdata;
            end
            phase_reg     <= phase_next;
            packet_id_reg <= packet_id_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            error_reg     <= error_next;
        end
    end

endmodule

// File: rtl/core/sspr_queue.sv
module sspr_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sspr_pkg::sspr_evt_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output sspr_pkg::sspr_evt_t pop_data
);
    import sspr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    sspr_evt_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/sspr_back.sv
module sspr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  sspr_pkg::sspr_evt_t q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          kind,
    output logic [7:0]          device_id,
    output logic [7:0]          status_error,
    output logic [7:0]          byte_index,
    output logic [7:0]          data_byte
);
    import sspr_pkg::*;

    logic      valid_reg;
    sspr_evt_t beat_reg;

    // refill the output register when it is empty or its beat leaves now
    assign q_pop = q_not_empty && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            beat_reg <= q_data;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = beat_reg.kind;
    assign device_id    = beat_reg.device_id;
    assign status_error = beat_reg.status_error;
    assign byte_index   = beat_reg.byte_index;
    assign data_byte    = beat_reg.data_byte;

endmodule

// File: rtl/core/servo_status_packet_receiver_unit.sv
// servo status packet receiver
// in channel: in_valid/in_ready carry one received bus byte (rx_byte) per beat.
// out channel: out_valid/out_ready carry zero or one result per input byte:
//   kind (parameter byte, packet good, bad checksum, bad length), device_id,
//   status_error, byte_index and data_byte.
// config: cfg_we writes cfg_wdata into max_length, the largest length byte
//   accepted; write only while the block is idle.
// throughput: one byte per cycle while in_ready is high; the header parser
//   finishes each byte in the cycle it is accepted, so nothing in the front loops over cycles.
// output path: a result's event enters the queue at the edge that accepts its
//   byte and moves into the output register when that register is empty or
//   its beat leaves.
// stall: a two-entry event queue sits between the parser and the output
//   register; in_ready drops only while that queue is full, so with the output
//   stalled up to three results are held before input is refused.
// reset: the parser hunts for the 0xFF 0xFF header, max_length returns to 255
//   and queue and output register are emptied.
module servo_status_packet_receiver_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] device_id,
    output logic [7:0] status_error,
    output logic [7:0] byte_index,
    output logic [7:0] data_byte
);
    import sspr_pkg::*;

    logic      accept;
    logic      evt_push;
    sspr_evt_t evt;
    logic      q_full;
    logic      q_pop;
    logic      q_not_empty;
    sspr_evt_t q_data;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    sspr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .evt_push  (evt_push),
        .evt       (evt)
    );

    sspr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (evt_push),
        .push_data (evt),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    sspr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .device_id    (device_id),
        .status_error (status_error),
        .byte_index   (byte_index),
        .data_byte    (data_byte)
    );

`ifndef NO_ASSERTIONS
    a_verdict_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_PARAM) |-> data_byte == 8'd0)
        else $error("verdict carries a data byte");

    a_bad_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_BAD_LEN) |-> (status_error == 8'd0 && byte_index == 8'd0))
        else $error("bad-length verdict carries error or index");

    a_param_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_PARAM) |-> (byte_index != 8'd254 && byte_index != 8'd255))
        else $error("parameter index out of range");

    a_queue_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (q_not_empty && !out_valid) |=> out_valid)
        else $error("queued event not moved to output");
`endif

endmodule
